### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check clocked on clk and switched off while reset is asserted.
`define BACC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check clocked on clk that also holds during reset.
`define BACC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bacc_pkg.sv
// ----------------------------------------------------------------------------
// bacc_pkg
// Shared types and constants of the block accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bacc_pkg;

  localparam int SUM_WIDTH_DEF = 48;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_MODE = 2'd0,
    CFG_FACTOR    = 2'd1,
    CFG_TOLERANCE = 2'd2
  } bacc_cfg_idx_t;

  localparam logic [15:0] FACTOR_RST = 16'd2;
  localparam logic [15:0] FACTOR_MIN = 16'd2;

  typedef struct packed {
    logic        time_mode;
    logic [15:0] block_factor;
    logic [15:0] time_tolerance;
  } bacc_cfg_t;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] real_value;
    logic signed [31:0] cplx_re;
    logic signed [31:0] cplx_im;
    logic               bad_flag;
  } bacc_sample_t;

endpackage

`default_nettype wire

### sv/bacc_in_if.sv
// ----------------------------------------------------------------------------
// bacc_in_if
// Sample channel: valid/ready handshake with one timestamped sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bacc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_time;
  logic signed [31:0] real_value;
  logic signed [31:0] cplx_re;
  logic signed [31:0] cplx_im;
  logic               bad_flag;

  modport source (
    output valid, sample_time, real_value, cplx_re, cplx_im, bad_flag,
    input  ready
  );
  modport sink (
    input  valid, sample_time, real_value, cplx_re, cplx_im, bad_flag,
    output ready
  );
endinterface

`default_nettype wire

### sv/bacc_out_if.sv
// ----------------------------------------------------------------------------
// bacc_out_if
// Block result channel: valid/ready handshake with one block result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bacc_out_if #(
  parameter int SUM_WIDTH = bacc_pkg::SUM_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [31:0]                 block_time;
  logic signed [SUM_WIDTH-1:0] real_sum;
  logic signed [SUM_WIDTH-1:0] cplx_re_sum;
  logic signed [SUM_WIDTH-1:0] cplx_im_sum;
  logic [31:0]                 dropped_runs;

  modport source (
    output valid, block_time, real_sum, cplx_re_sum, cplx_im_sum, dropped_runs,
    input  ready
  );
  modport sink (
    input  valid, block_time, real_sum, cplx_re_sum, cplx_im_sum, dropped_runs,
    output ready
  );
endinterface

`default_nettype wire

### sv/bacc_sat_add.sv
// ----------------------------------------------------------------------------
// bacc_sat_add
// Adds a signed 32-bit sample to a signed accumulator, clamping on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module bacc_sat_add #(
  parameter int SUM_WIDTH = bacc_pkg::SUM_WIDTH_DEF
) (
  input  wire logic signed [SUM_WIDTH-1:0] acc,
  input  wire logic signed [31:0]          x,
  output logic signed [SUM_WIDTH-1:0]      sum
);

  logic [SUM_WIDTH:0] wide;

  assign wide = {acc[SUM_WIDTH-1], acc} + {{(SUM_WIDTH+1-32){x[31]}}, x};

  // The two top bits differ only when the true sum left the signed range.
  always_comb begin
    if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
      sum = wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                            : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum = wide[SUM_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/bacc_core.sv
// ----------------------------------------------------------------------------
// bacc_core
// Block state and the per-sample update for count and time framing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bacc_core #(
  parameter int SUM_WIDTH = bacc_pkg::SUM_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire bacc_pkg::bacc_sample_t       smp,
  input  wire bacc_pkg::bacc_cfg_t          cfg,
  output logic                              res_emit,
  output logic [31:0]                       res_block_time,
  output logic signed [SUM_WIDTH-1:0]       res_real_sum,
  output logic signed [SUM_WIDTH-1:0]       res_cplx_re_sum,
  output logic signed [SUM_WIDTH-1:0]       res_cplx_im_sum,
  output logic [31:0]                       res_dropped
);

  logic signed [SUM_WIDTH-1:0] acc_real_r, acc_real_nxt;
  logic signed [SUM_WIDTH-1:0] acc_re_r, acc_re_nxt;
  logic signed [SUM_WIDTH-1:0] acc_im_r, acc_im_nxt;
  logic [31:0]                 run_start_r, run_start_nxt;
  logic [15:0]                 run_count_r, run_count_nxt;
  logic                        start_pending_r, start_pending_nxt;
  logic [31:0]                 drop_cnt_r, drop_cnt_nxt;

  logic signed [SUM_WIDTH-1:0] add_real, add_re, add_im;
  logic signed [SUM_WIDTH-1:0] load_real, load_re, load_im;
  logic [15:0]                 factor;
  logic [15:0]                 count_inc;
  logic [31:0]                 start_cnt, start_tim;
  logic signed [33:0]          delta, tol;
  logic                        in_window, too_late;

  bacc_sat_add #(.SUM_WIDTH(SUM_WIDTH)) u_add_real (
    .acc(acc_real_r), .x(smp.real_value), .sum(add_real)
  );
  bacc_sat_add #(.SUM_WIDTH(SUM_WIDTH)) u_add_re (
    .acc(acc_re_r), .x(smp.cplx_re), .sum(add_re)
  );
  bacc_sat_add #(.SUM_WIDTH(SUM_WIDTH)) u_add_im (
    .acc(acc_im_r), .x(smp.cplx_im), .sum(add_im)
  );

  always_comb begin
    factor    = (cfg.block_factor < bacc_pkg::FACTOR_MIN) ? bacc_pkg::FACTOR_MIN
                                                          : cfg.block_factor;
    count_inc = run_count_r + 16'd1;
    start_cnt = (run_count_r == 16'd0) ? smp.sample_time : run_start_r;
    start_tim = start_pending_r ? smp.sample_time : run_start_r;

    // Signed elapsed time minus window, wide enough to never wrap.
    delta = $signed({2'b00, smp.sample_time}) - $signed({2'b00, start_tim})
            - $signed({18'd0, factor});
    tol   = $signed({18'd0, cfg.time_tolerance});
    in_window = (delta >= -tol) && (delta <= tol);
    too_late  = delta > tol;

    load_real = smp.bad_flag ? '0 : {{(SUM_WIDTH-32){smp.real_value[31]}}, smp.real_value};
    load_re   = smp.bad_flag ? '0 : {{(SUM_WIDTH-32){smp.cplx_re[31]}}, smp.cplx_re};
    load_im   = smp.bad_flag ? '0 : {{(SUM_WIDTH-32){smp.cplx_im[31]}}, smp.cplx_im};

    acc_real_nxt      = smp.bad_flag ? acc_real_r : add_real;
    acc_re_nxt        = smp.bad_flag ? acc_re_r : add_re;
    acc_im_nxt        = smp.bad_flag ? acc_im_r : add_im;
    run_count_nxt     = run_count_r;
    start_pending_nxt = start_pending_r;
    drop_cnt_nxt      = drop_cnt_r;
    run_start_nxt     = run_start_r;

    res_emit        = 1'b0;
    res_block_time  = start_cnt;
    res_real_sum    = acc_real_nxt;
    res_cplx_re_sum = acc_re_nxt;
    res_cplx_im_sum = acc_im_nxt;
    res_dropped     = drop_cnt_r;

    if (!cfg.time_mode) begin
      run_start_nxt = start_cnt;
      if (count_inc >= factor) begin
        res_emit      = 1'b1;
        run_count_nxt = '0;
        acc_real_nxt  = '0;
        acc_re_nxt    = '0;
        acc_im_nxt    = '0;
      end else begin
        run_count_nxt = count_inc;
      end
    end else begin
      start_pending_nxt = 1'b0;
      res_block_time    = start_tim;
      res_real_sum      = acc_real_r;
      res_cplx_re_sum   = acc_re_r;
      res_cplx_im_sum   = acc_im_r;
      run_start_nxt     = start_tim;
      if (in_window || too_late) begin
        // The sample that closes or restarts a run opens the next one.
        res_emit      = in_window;
        run_start_nxt = smp.sample_time;
        acc_real_nxt  = load_real;
        acc_re_nxt    = load_re;
        acc_im_nxt    = load_im;
        if (too_late) begin
          drop_cnt_nxt = drop_cnt_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_real_r      <= '0;
      acc_re_r        <= '0;
      acc_im_r        <= '0;
      run_start_r     <= '0;
      run_count_r     <= '0;
      start_pending_r <= 1'b1;
      drop_cnt_r      <= '0;
    end else if (step) begin
      acc_real_r      <= acc_real_nxt;
      acc_re_r        <= acc_re_nxt;
      acc_im_r        <= acc_im_nxt;
      run_start_r     <= run_start_nxt;
      run_count_r     <= run_count_nxt;
      start_pending_r <= start_pending_nxt;
      drop_cnt_r      <= drop_cnt_nxt;
    end
  end

  `BACC_ASSERT(a_pending_once, clk, rst_n, !start_pending_r |=> !start_pending_r, "start pending set again")
  `BACC_ASSERT(a_drop_time_only, clk, rst_n, (drop_cnt_r != $past(drop_cnt_r)) |-> $past(step && cfg.time_mode), "drop counter moved outside a time-mode sample")

endmodule

`default_nettype wire

### sv/block_accumulator_count_or_time.sv
// ----------------------------------------------------------------------------
// block_accumulator_count_or_time
// Integrate-and-dump accumulator with count or time-window block framing.
// ----------------------------------------------------------------------------
// Samples arrive on in_ch (valid/ready); a transfer takes one timestamped
// sample into an input register. Block results leave on out_ch from a
// result register. Registers are written through cfg_we/cfg_idx/cfg_wdata;
// the user must write them only while no sample is in flight, and the
// block itself has no guard for this. The core sits between the input and
// result registers: a sample is held first in the input register and, once
// the result register is free, the block that it closes is written into the
// result register, from which it is valid on out_ch. While out_ch is not
// stalled, one sample can be taken every cycle as the core updates the three
// SUM_WIDTH-bit sums. A sample that closes no block leaves no result.
// When the receiver holds out_ch.ready low, the result stays in its
// register and the input register stalls behind it, so in_ch.ready falls
// only while both are full.
// Synchronous reset clears the sums, the run state, the drop counter and
// both valid flags, and loads the register reset values; the first time-mode
// sample after reset starts the first run.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module block_accumulator_count_or_time #(
  parameter int SUM_WIDTH = bacc_pkg::SUM_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bacc_in_if.sink                               in_ch,
  bacc_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [bacc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [bacc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  bacc_pkg::bacc_cfg_t    cfg_r;
  bacc_pkg::bacc_sample_t s1_data_r;
  logic                   s1_valid_r;
  logic                   out_valid_r;
  logic                   out_free, advance;

  logic                        res_emit;
  logic [31:0]                 res_block_time, res_dropped;
  logic signed [SUM_WIDTH-1:0] res_real_sum, res_cplx_re_sum, res_cplx_im_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_mode      <= 1'b0;
      cfg_r.block_factor   <= bacc_pkg::FACTOR_RST;
      cfg_r.time_tolerance <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bacc_pkg::CFG_TIME_MODE: cfg_r.time_mode      <= cfg_wdata[0];
        bacc_pkg::CFG_FACTOR:    cfg_r.block_factor   <= cfg_wdata;
        bacc_pkg::CFG_TOLERANCE: cfg_r.time_tolerance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r.sample_time <= in_ch.sample_time;
      s1_data_r.real_value  <= in_ch.real_value;
      s1_data_r.cplx_re     <= in_ch.cplx_re;
      s1_data_r.cplx_im     <= in_ch.cplx_im;
      s1_data_r.bad_flag    <= in_ch.bad_flag;
    end
  end

  bacc_core #(.SUM_WIDTH(SUM_WIDTH)) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .smp             (s1_data_r),
    .cfg             (cfg_r),
    .res_emit        (res_emit),
    .res_block_time  (res_block_time),
    .res_real_sum    (res_real_sum),
    .res_cplx_re_sum (res_cplx_re_sum),
    .res_cplx_im_sum (res_cplx_im_sum),
    .res_dropped     (res_dropped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_emit) begin
      out_ch.block_time   <= res_block_time;
      out_ch.real_sum     <= res_real_sum;
      out_ch.cplx_re_sum  <= res_cplx_re_sum;
      out_ch.cplx_im_sum  <= res_cplx_im_sum;
      out_ch.dropped_runs <= res_dropped;
    end
  end

  assign out_ch.valid = out_valid_r;

  `BACC_ASSERT(a_out_from_s1, clk, rst_n, $rose(out_valid_r) |-> $past(s1_valid_r), "result appeared with no sample in the input register")
  `BACC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!s1_valid_r && !out_valid_r), "valid flags not cleared by reset")

endmodule

`default_nettype wire

### dv/block_accumulator_count_or_time_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_accumulator_count_or_time_tb
// Self-checking bench for the count/time-window block accumulator.
// Samples go in through a valid/ready channel with random gaps. Each accepted
// sample is run through a bit-accurate accumulator model kept in the bench,
// and every block it closes is queued. Each block result taken from the
// output channel, which stalls at random, is compared field by field with
// the oldest queued block. Directed cases cover both framing modes, the
// degenerate factors, a factor lowered in the middle of a run and a long run
// of full-scale samples. Randomised phases with random register settings
// follow.
// ----------------------------------------------------------------------------

module block_accumulator_count_or_time_tb;

  localparam int     SW     = bacc_pkg::SUM_WIDTH_DEF;
  localparam longint SUM_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct {
    logic [31:0]          block_time;
    logic signed [SW-1:0] real_sum;
    logic signed [SW-1:0] cplx_re_sum;
    logic signed [SW-1:0] cplx_im_sum;
    logic [31:0]          dropped_runs;
  } block_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  bacc_pkg::bacc_cfg_idx_t cfg_idx = bacc_pkg::CFG_TIME_MODE;
  logic [15:0]             cfg_wdata = '0;

  bacc_in_if                    in_ch ();
  bacc_out_if #(.SUM_WIDTH(SW)) out_ch ();

  block_accumulator_count_or_time #(.SUM_WIDTH(SW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Accumulator model state and its copy of the registers.
  bit          mode_time = 1'b0;
  bit [15:0]   factor_reg = 16'd2;
  bit [15:0]   tol_reg = 16'd0;
  longint      sum_real = 0;
  longint      sum_re = 0;
  longint      sum_im = 0;
  bit [31:0]   run_start = '0;
  bit [15:0]   run_len = '0;
  bit          awaiting_first = 1'b1;
  bit [31:0]   drops = '0;

  block_result_t pending_blocks[$];
  bit            idle_on = 1'b0;
  int            n_samples = 0;
  int            n_blocks = 0;
  int            n_errors = 0;

  function automatic longint sat_sum(input longint acc, input longint x);
    longint s;
    s = acc + x;
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  function automatic void add_to_sums(input bacc_pkg::bacc_sample_t s);
    if (!s.bad_flag) begin
      sum_real = sat_sum(sum_real, longint'(s.real_value));
      sum_re   = sat_sum(sum_re, longint'(s.cplx_re));
      sum_im   = sat_sum(sum_im, longint'(s.cplx_im));
    end
  endfunction

  // A new time-mode run starts holding the sample that opened it.
  function automatic void restart_sums(input bacc_pkg::bacc_sample_t s);
    sum_real = s.bad_flag ? 0 : longint'(s.real_value);
    sum_re   = s.bad_flag ? 0 : longint'(s.cplx_re);
    sum_im   = s.bad_flag ? 0 : longint'(s.cplx_im);
  endfunction

  function automatic block_result_t current_block();
    block_result_t b;
    b.block_time   = run_start;
    b.real_sum     = sum_real[SW-1:0];
    b.cplx_re_sum  = sum_re[SW-1:0];
    b.cplx_im_sum  = sum_im[SW-1:0];
    b.dropped_runs = drops;
    return b;
  endfunction

  function automatic bit accumulate_sample(input bacc_pkg::bacc_sample_t s,
                                           output block_result_t b);
    longint eff;
    longint tol;
    longint delta;
    eff = (factor_reg < 16'd2) ? 2 : longint'(factor_reg);
    tol = longint'(tol_reg);
    b = current_block();
    if (!mode_time) begin
      if (run_len == 16'd0) run_start = s.sample_time;
      add_to_sums(s);
      run_len = run_len + 16'd1;
      if (longint'(run_len) >= eff) begin
        b = current_block();
        run_len  = '0;
        sum_real = 0;
        sum_re   = 0;
        sum_im   = 0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      run_start = s.sample_time;
    end
    delta = longint'(s.sample_time) - longint'(run_start) - eff;
    if (delta >= -tol && delta <= tol) begin
      b = current_block();
      run_start = s.sample_time;
      restart_sums(s);
      return 1'b1;
    end
    if (delta > tol) begin
      drops = drops + 32'd1;
      run_start = s.sample_time;
      restart_sums(s);
      return 1'b0;
    end
    add_to_sums(s);
    return 1'b0;
  endfunction

  function automatic bacc_pkg::bacc_sample_t mk_sample(input bit [31:0] t,
                                                      input bit [31:0] r,
                                                      input bit [31:0] cr,
                                                      input bit [31:0] ci,
                                                      input bit bad);
    bacc_pkg::bacc_sample_t s;
    s.sample_time = t;
    s.real_value  = r;
    s.cplx_re     = cr;
    s.cplx_im     = ci;
    s.bad_flag    = bad;
    return s;
  endfunction

  // Random value leaning towards the extremes of Q16.16.
  function automatic bit [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic bacc_pkg::bacc_sample_t rand_sample(input bit [31:0] t);
    return mk_sample(t, rand_value(), rand_value(), rand_value(), $urandom_range(0, 7) == 0);
  endfunction

  // Time-mode stimulus aimed at the model's current run so that windows close,
  // runs are dropped and late or early samples land inside a run.
  function automatic bacc_pkg::bacc_sample_t time_mode_sample();
    longint eff;
    longint tol;
    longint t;
    eff = (factor_reg < 16'd2) ? 2 : longint'(factor_reg);
    tol = longint'(tol_reg);
    case ($urandom_range(0, 9))
      0, 1, 2: t = longint'(run_start) + eff + longint'($urandom_range(0, 2 * tol)) - tol;
      3:       t = longint'(run_start) + eff + tol + 1 + longint'($urandom_range(0, 5000));
      4:       t = longint'(run_start) - longint'($urandom_range(1, 2000));
      5:       t = longint'($urandom);
      default: t = longint'(run_start) + longint'($urandom_range(0, eff - 1));
    endcase
    return rand_sample(t[31:0]);
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) flag_error($sformatf("%s expected %h, got %h", name, want, got));
  endtask

  // Output is settled by the falling edge, so a transfer at the next rising
  // edge is seen here without racing the block's own update.
  always @(negedge clk) begin : check_blocks
    block_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_blocks.size() == 0) begin
        flag_error("block result arrived with no block expected");
      end else begin
        want = pending_blocks.pop_front();
        n_blocks++;
        check_field("block_time", want.block_time, out_ch.block_time);
        check_field("real_sum", want.real_sum, out_ch.real_sum);
        check_field("cplx_re_sum", want.cplx_re_sum, out_ch.cplx_re_sum);
        check_field("cplx_im_sum", want.cplx_im_sum, out_ch.cplx_im_sum);
        check_field("dropped_runs", want.dropped_runs, out_ch.dropped_runs);
      end
    end
  end

  // Receiver: ready high, with random stall bursts while idling is enabled.
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Valid stays high from one sample to the next unless a gap is taken.
  task automatic send_sample(input bacc_pkg::bacc_sample_t s);
    block_result_t b;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_time <= s.sample_time;
    in_ch.real_value  <= s.real_value;
    in_ch.cplx_re     <= s.cplx_re;
    in_ch.cplx_im     <= s.cplx_im;
    in_ch.bad_flag    <= s.bad_flag;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    if (accumulate_sample(s, b)) pending_blocks.push_back(b);
    n_samples++;
  endtask

  // Valid is dropped and the bench waits until every expected block has been
  // taken, then lets the core settle before the block counts as idle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_apply(input bit mode, input bit [15:0] factor, input bit [15:0] tol);
    cfg_we    <= 1'b1;
    cfg_idx   <= bacc_pkg::CFG_TIME_MODE;
    cfg_wdata <= {15'($urandom), mode};
    @(posedge clk);
    cfg_idx   <= bacc_pkg::CFG_FACTOR;
    cfg_wdata <= factor;
    @(posedge clk);
    cfg_idx   <= bacc_pkg::CFG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_we     <= 1'b0;
    mode_time  = mode;
    factor_reg = factor;
    tol_reg    = tol;
  endtask

  // With the tolerance at or above the window, the first time-mode sample
  // closes an empty block straight away.
  task automatic test_first_time_sample();
    wait_idle();
    cfg_apply(1'b1, 16'd4, 16'd6);
    send_sample(mk_sample(32'd1000, 32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 1'b0));
    send_sample(mk_sample(32'd1003, 32'h8000_0000, 32'h0000_8000, 32'h0000_0001, 1'b0));
  endtask

  task automatic test_time_windows();
    wait_idle();
    cfg_apply(1'b1, 16'd100, 16'd3);
    send_sample(mk_sample(run_start + 32'd10, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 1'b0));
    send_sample(mk_sample(run_start + 32'd20, 32'h1234_5678, 32'h1234_5678,
                          32'h1234_5678, 1'b1));
    // Time running backwards stays in the current run.
    send_sample(mk_sample(run_start - 32'd50, 32'hFFFF_FFFF, 32'h0000_0001,
                          32'h8000_0000, 1'b0));
    send_sample(mk_sample(run_start + 32'd97, 32'h0000_0100, 32'h0000_0200,
                          32'h0000_0300, 1'b0));
    send_sample(mk_sample(run_start + 32'd103, 32'h0000_0001, 32'h0000_0002,
                          32'h0000_0003, 1'b1));
    send_sample(mk_sample(run_start + 32'd500, 32'h0002_0000, 32'hFFFF_0000,
                          32'h0000_0004, 1'b0));
    send_sample(mk_sample(run_start + 32'd5, 32'h0000_0005, 32'h0000_0006,
                          32'h0000_0007, 1'b0));
    send_sample(mk_sample(run_start + 32'd100, 32'h0000_0008, 32'h0000_0009,
                          32'h0000_000A, 1'b0));
  endtask

  // A long time-mode run of full-scale samples builds sums well beyond 32
  // bits, then backs off with opposite values before the window closes.
  task automatic test_long_run();
    bit [31:0] t0;
    wait_idle();
    idle_on = 1'b0;
    cfg_apply(1'b1, 16'hFFFF, 16'd0);
    t0 = run_start + 32'd65535;
    send_sample(mk_sample(t0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    repeat (100)
      send_sample(mk_sample(t0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    repeat (8)
      send_sample(mk_sample(t0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b0));
    send_sample(mk_sample(t0 + 32'd65535, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0));
  endtask

  task automatic test_count_basics();
    wait_idle();
    idle_on = 1'b1;
    cfg_apply(1'b0, 16'd2, 16'd0);
    send_sample(mk_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_sample(mk_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_sample(mk_sample(32'h0000_0005, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_sample(mk_sample(32'h0000_0006, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_sample(mk_sample(32'hAAAA_5555, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1));
    send_sample(mk_sample(32'h5555_AAAA, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
  endtask

  // Factors of zero and one behave as two in both modes.
  task automatic test_small_factor();
    wait_idle();
    cfg_apply(1'b0, 16'd0, 16'd0);
    send_sample(rand_sample($urandom));
    send_sample(rand_sample($urandom));
    wait_idle();
    cfg_apply(1'b0, 16'd1, 16'd0);
    send_sample(rand_sample($urandom));
    send_sample(rand_sample($urandom));
    wait_idle();
    cfg_apply(1'b1, 16'd1, 16'd0);
    send_sample(rand_sample(run_start + 32'd2));
    send_sample(rand_sample(run_start + 32'd1));
  endtask

  // Lowering the factor below the current count closes the block on the
  // next sample.
  task automatic test_factor_lowered();
    wait_idle();
    cfg_apply(1'b0, 16'd10, 16'd0);
    repeat (6) send_sample(rand_sample($urandom));
    wait_idle();
    cfg_apply(1'b0, 16'd4, 16'd0);
    send_sample(rand_sample($urandom));
  endtask

  // Random phases: each writes all three registers, then streams samples
  // without clearing the shared state, so mode and factor changes land
  // part-way through runs.
  task automatic test_random_framing(input int n_items, input bit with_idling);
    int        sent;
    bit        mode;
    bit [15:0] factor;
    bit [15:0] tol;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      idle_on = with_idling;
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       factor = 16'($urandom_range(0, 1));
        1:       factor = 16'hFFFF;
        2:       factor = 16'($urandom_range(2, 65535));
        default: factor = mode ? 16'($urandom_range(2, 300)) : 16'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       tol = 16'd0;
        1:       tol = 16'hFFFF;
        2:       tol = factor;
        default: tol = 16'($urandom_range(0, factor / 4));
      endcase
      cfg_apply(mode, factor, tol);
      repeat ($urandom_range(15, 90)) begin
        send_sample(mode ? time_mode_sample() : rand_sample($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.sample_time <= '0;
    in_ch.real_value  <= '0;
    in_ch.cplx_re     <= '0;
    in_ch.cplx_im     <= '0;
    in_ch.bad_flag    <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_time_sample();
    test_time_windows();
    test_long_run();
    test_count_basics();
    test_small_factor();
    test_factor_lowered();
    test_random_framing(1400, 1'b1);
    test_random_framing(250, 1'b0);

    wait_idle();
    if (pending_blocks.size() != 0)
      flag_error($sformatf("%0d block results never arrived", pending_blocks.size()));
    $display("Run covered %0d samples and %0d checked block results in count and time modes,",
             n_samples, n_blocks);
    $display("including %0d dropped runs and a long run of full-scale samples.", drops);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout: the run did not finish in the allowed time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
